// File: src/co2q_pkg.sv
package co2q_pkg;

  // input function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // result kinds
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // reading status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
  localparam logic [1:0] STATUS_CSUM    = 2'd2;

  localparam int unsigned FRAME_LEN = 9;
  localparam logic [3:0] FRAME_LAST = 4'(FRAME_LEN - 1);
  localparam logic [3:0] SUM_FIRST  = 4'd1;
  localparam logic [3:0] SUM_LAST   = 4'd7;
  localparam logic [3:0] IDX_HIGH   = 4'd2;
  localparam logic [3:0] IDX_LOW    = 4'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  // finished reading from the reply tracker
  typedef struct packed {
    logic        fire;
    logic [1:0]  status;
    logic [15:0] conc;
  } reply_t;

  // gas concentration read command frame
  function automatic logic [7:0] frame_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'hff;
      4'd1:    b = 8'h01;
      4'd2:    b = 8'h86;
      4'd8:    b = 8'h79;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: src/co2q_reply.sv
module co2q_reply (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [1:0]           func,
  input  logic [7:0]           rx_byte,
  input  logic [15:0]          timeout_ticks,
  output co2q_pkg::reply_t     res
);

  logic        waiting,      waiting_next;
  logic [3:0]  bytes_seen,   bytes_seen_next;
  logic [7:0]  running_sum,  running_sum_next;
  logic [7:0]  value_high,   value_high_next;
  logic [7:0]  value_low,    value_low_next;
  logic [15:0] ticks_waited, ticks_waited_next;

  logic [15:0] limit;
  logic [15:0] ticks_inc;
  logic [7:0]  want;

  always_comb begin
    limit     = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
    ticks_inc = ticks_waited + 16'd1;
    want      = 8'd0 - running_sum;

    waiting_next      = waiting;
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;
    value_high_next   = value_high;
    value_low_next    = value_low;
    ticks_waited_next = ticks_waited;
    res               = '0;

    if (fire) begin
      if (func == co2q_pkg::FUNC_START) begin
        waiting_next      = 1'b1;
        bytes_seen_next   = '0;
        running_sum_next  = '0;
        value_high_next   = '0;
        value_low_next    = '0;
        ticks_waited_next = '0;
      end else if (waiting && func == co2q_pkg::FUNC_BYTE) begin
        if (bytes_seen >= co2q_pkg::FRAME_LAST) begin
          // ninth byte: checksum against the sum of bytes 1..7
          res.fire          = 1'b1;
          res.status        = (rx_byte == want) ? co2q_pkg::STATUS_OK : co2q_pkg::STATUS_CSUM;
          res.conc          = (rx_byte == want) ? {value_high, value_low} : 16'd0;
          waiting_next      = 1'b0;
          bytes_seen_next   = '0;
          running_sum_next  = '0;
          value_high_next   = '0;
          value_low_next    = '0;
          ticks_waited_next = '0;
        end else begin
          if (bytes_seen >= co2q_pkg::SUM_FIRST && bytes_seen <= co2q_pkg::SUM_LAST)
            running_sum_next = running_sum + rx_byte;
          if (bytes_seen == co2q_pkg::IDX_HIGH) value_high_next = rx_byte;
          if (bytes_seen == co2q_pkg::IDX_LOW)  value_low_next  = rx_byte;
          bytes_seen_next = bytes_seen + 4'd1;
        end
      end else if (waiting && func == co2q_pkg::FUNC_TICK) begin
        if (ticks_inc >= limit) begin
          res.fire          = 1'b1;
          res.status        = co2q_pkg::STATUS_TIMEOUT;
          waiting_next      = 1'b0;
          bytes_seen_next   = '0;
          running_sum_next  = '0;
          value_high_next   = '0;
          value_low_next    = '0;
          ticks_waited_next = '0;
        end else begin
          ticks_waited_next = ticks_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting      <= 1'b0;
      bytes_seen   <= '0;
      running_sum  <= '0;
      value_high   <= '0;
      value_low    <= '0;
      ticks_waited <= '0;
    end else begin
      waiting      <= waiting_next;
      bytes_seen   <= bytes_seen_next;
      running_sum  <= running_sum_next;
      value_high   <= value_high_next;
      value_low    <= value_low_next;
      ticks_waited <= ticks_waited_next;
    end
  end

  // idle tracker holds no partial reply
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !waiting |-> (bytes_seen == 4'd0 && ticks_waited == 16'd0 && running_sum == 8'd0))
    else $error("reply state left over while idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= co2q_pkg::FRAME_LAST)
    else $error("reply byte count past frame end");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.fire |=> !waiting)
    else $error("tracker still waiting after finished reading");

endmodule

// File: src/co2_sensor_uart_query.sv
// CO2 sensor UART query. A start word sends the nine-byte gas concentration
// read frame (FF 01 86 00 00 00 00 00 79) as nine tx words, the ninth with
// last set, then collects the nine-byte reply from received-byte words. On
// the ninth reply byte one done word reports the concentration (byte2:byte3)
// or a checksum error; tick words count toward timeout_ticks and report a
// short reply when it is reached (zero acts as one). Byte and tick words
// while idle, and func code 3, are dropped with no result. Rate: byte and
// tick words are taken one per cycle, back to back while the output is not
// stalled, through the single output register; a start word holds off the
// input for eight output transfers while the frame sequencer walks the
// command table, and the next word is taken together with the ninth
// transfer. Config writes are always ready.
module co2_sensor_uart_query (
  input  logic        clk,
  input  logic        rst,
  // config: timeout_ticks
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [1:0]  status,
  output logic [15:0] concentration
);

  logic [15:0]      timeout_ticks;
  logic             sending;     // frame bytes still to be loaded
  logic [3:0]       frame_idx;   // next frame byte to load
  logic             in_fire;
  logic             out_free;
  logic             is_start;
  co2q_pkg::reply_t reply;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  // input stalls only for a full output slot or a frame in flight
  assign in_ready  = out_free && !sending;
  assign in_fire   = in_valid && in_ready;
  assign is_start  = (func == co2q_pkg::FUNC_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= co2q_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  co2q_reply u_reply (
    .clk           (clk),
    .rst           (rst),
    .fire          (in_fire),
    .func          (func),
    .rx_byte       (rx_byte),
    .timeout_ticks (timeout_ticks),
    .res           (reply)
  );

  // output register and frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sending   <= 1'b0;
      frame_idx <= '0;
    end else if (in_fire && is_start) begin
      out_valid <= 1'b1;
      sending   <= 1'b1;
      frame_idx <= 4'd1;
    end else if (in_fire && reply.fire) begin
      out_valid <= 1'b1;
    end else if (sending && out_ready) begin
      out_valid <= 1'b1;
      sending   <= (frame_idx != co2q_pkg::FRAME_LAST);
      frame_idx <= frame_idx + 4'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && is_start) begin
      kind          <= co2q_pkg::KIND_TX;
      tx_byte       <= co2q_pkg::frame_byte(4'd0);
      last          <= 1'b0;
      status        <= co2q_pkg::STATUS_OK;
      concentration <= '0;
    end else if (in_fire && reply.fire) begin
      kind          <= co2q_pkg::KIND_DONE;
      tx_byte       <= '0;
      last          <= 1'b0;
      status        <= reply.status;
      concentration <= reply.conc;
    end else if (sending && out_ready) begin
      kind          <= co2q_pkg::KIND_TX;
      tx_byte       <= co2q_pkg::frame_byte(frame_idx);
      last          <= (frame_idx == co2q_pkg::FRAME_LAST);
      status        <= co2q_pkg::STATUS_OK;
      concentration <= '0;
    end
  end

  a_send_valid: assert property (@(posedge clk) disable iff (rst)
    sending |-> out_valid)
    else $error("frame in flight with empty output slot");

  a_start_head: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_start) |=> (out_valid && kind == co2q_pkg::KIND_TX && tx_byte == 8'hff))
    else $error("start word did not open frame");

  a_last_tx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (kind == co2q_pkg::KIND_TX && tx_byte == 8'h79 && !sending))
    else $error("last marker on wrong word");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == co2q_pkg::KIND_DONE) |-> (tx_byte == 8'd0 && !sending))
    else $error("done word mixed with frame");

endmodule

// File: bench/tb_co2_sensor_uart_query.sv
module tb_co2_sensor_uart_query;
  timeunit 1ns;
  timeprecision 1ps;

  // func code 3 has no name in the package; the block drops it
  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
  // gas concentration read command, byte 0 in the top bits
  localparam logic [71:0] READ_CMD      = 72'hff_01_86_00_00_00_00_00_79;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_WORDS  = 120;
  localparam int unsigned PHASES        = 6;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic [1:0]  status;
    logic [15:0] conc;
  } result_word_t;

  // Tracks the query/reply protocol and holds the result words still due.
  class reading_scoreboard;
    logic [15:0]  timeout_ticks;
    bit           waiting;
    logic [3:0]   seen;
    logic [7:0]   sum;
    logic [7:0]   hi;
    logic [7:0]   lo;
    logic [15:0]  ticks;
    result_word_t due_words[$];
    int           errors;

    function new();
      timeout_ticks = co2q_pkg::TIMEOUT_RESET;
      waiting = 1'b0;
      errors = 0;
      clear_reply();
    endfunction

    function void clear_reply();
      seen = '0;
      sum = '0;
      hi = '0;
      lo = '0;
      ticks = '0;
    endfunction

    function void push_done(logic [1:0] st, logic [15:0] conc);
      due_words.push_back({co2q_pkg::KIND_DONE, 8'h00, 1'b0, st, conc});
    endfunction

    // accepted input word: work out the result words it causes
    function void note_word(logic [1:0] f, logic [7:0] b);
      logic [15:0] lim;
      logic [7:0]  want;
      if (f == co2q_pkg::FUNC_START) begin
        // a new request drops any reply in progress
        clear_reply();
        waiting = 1'b1;
        for (int k = 0; k < co2q_pkg::FRAME_LEN; k++)
          due_words.push_back({co2q_pkg::KIND_TX, READ_CMD[71 - 8 * k -: 8],
                               k == co2q_pkg::FRAME_LEN - 1,
                               co2q_pkg::STATUS_OK, 16'h0000});
      end else if (waiting && f == co2q_pkg::FUNC_BYTE) begin
        if (seen >= co2q_pkg::SUM_FIRST && seen <= co2q_pkg::SUM_LAST) sum += b;
        if (seen == co2q_pkg::IDX_HIGH) hi = b;
        if (seen == co2q_pkg::IDX_LOW) lo = b;
        if (seen >= co2q_pkg::FRAME_LAST) begin
          want = ~sum + 8'd1;
          waiting = 1'b0;
          if (b == want) push_done(co2q_pkg::STATUS_OK, {hi, lo});
          else push_done(co2q_pkg::STATUS_CSUM, 16'h0000);
          clear_reply();
        end else begin
          seen++;
        end
      end else if (waiting && f == co2q_pkg::FUNC_TICK) begin
        // zero acts as one
        lim = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
        ticks++;
        if (ticks >= lim) begin
          waiting = 1'b0;
          clear_reply();
          push_done(co2q_pkg::STATUS_TIMEOUT, 16'h0000);
        end
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // accepted result word: compare with the oldest one due
    function void check_word(result_word_t got);
      result_word_t want;
      if (due_words.size() == 0) begin
        $error("result word with none due: kind %0d tx %02h last %0d status %0d conc %04h",
               got.kind, got.tx, got.last, got.status, got.conc);
        errors++;
        return;
      end
      want = due_words.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("tx_byte", 16'(want.tx), 16'(got.tx));
      compare_field("last", 16'(want.last), 16'(got.last));
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("concentration", want.conc, got.conc);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = co2q_pkg::FUNC_TICK;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [1:0]  status;
  logic [15:0] concentration;

  bit          steady = 1'b0;     // no gaps and no stalls while set
  bit          hold_req = 1'b0;   // asks the receiver for one long hold-off
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  logic [15:0] cur_timeout = co2q_pkg::TIMEOUT_RESET;

  reading_scoreboard board = new();

  always #10 clk = ~clk;

  co2_sensor_uart_query DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .tx_byte       (tx_byte),
    .last          (last),
    .status        (status),
    .concentration (concentration)
  );

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("co2_sensor_uart_query regression: fail");
      $finish;
    end
  end

  // result monitor: values sampled here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_word({kind, tx_byte, last, status, concentration});
  end

  // mostly no gap, some short ones, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: at most one ready update per edge; a hold request forces a long stall
  initial begin
    int unsigned stall;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = idle_len();
      end
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  // offer one input word, note it when taken, then maybe leave a gap
  task automatic offer(input logic [1:0] f, input logic [7:0] b);
    int unsigned gap;
    in_valid <= 1'b1;
    func     <= f;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    board.note_word(f, b);
    words_sent++;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every due word is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.timeout_ticks = v;
    cur_timeout = v;
    cfg_valid <= 1'b0;
  endtask

  // nine reply bytes; header and filler random when scrambled, checksum
  // correct unless corrupted, stray ticks mixed in when noisy
  task automatic send_reply(input logic [7:0] hi, input logic [7:0] lo,
                            input bit scramble, input bit corrupt, input bit noisy);
    logic [7:0] frame [9];
    logic [7:0] sum;
    frame[0] = scramble ? 8'($urandom) : 8'hff;
    frame[1] = scramble ? 8'($urandom) : 8'h86;
    frame[2] = hi;
    frame[3] = lo;
    for (int k = 4; k < 8; k++) frame[k] = scramble ? 8'($urandom) : 8'h00;
    sum = 8'h00;
    for (int k = 1; k < 8; k++) sum += frame[k];
    frame[8] = ~sum + 8'd1;
    if (corrupt) frame[8] ^= 8'($urandom_range(1, 255));
    for (int k = 0; k < 9; k++) begin
      if (noisy && $urandom_range(0, 7) == 0) offer(co2q_pkg::FUNC_TICK, 8'($urandom));
      offer(co2q_pkg::FUNC_BYTE, frame[k]);
    end
  endtask

  // mostly complete query/reply exchanges, some cut-off replies, a few noise words
  task automatic random_sequence();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      offer(co2q_pkg::FUNC_START, 8'($urandom));
      send_reply(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 3) == 0, 1'b1);
    end else if (r < 88) begin
      offer(co2q_pkg::FUNC_START, 8'($urandom));
      n = $urandom_range(0, co2q_pkg::FRAME_LEN - 1);
      repeat (n) offer(co2q_pkg::FUNC_BYTE, 8'($urandom));
      // run the timer out when the limit is within reach
      n = (cur_timeout <= 16'd8) ? cur_timeout + 1 : $urandom_range(0, 4);
      repeat (n) offer(co2q_pkg::FUNC_TICK, 8'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) offer(2'($urandom_range(co2q_pkg::FUNC_BYTE, FUNC_UNUSED)), 8'($urandom));
    end
  endtask

  initial begin
    int unsigned target;
    logic [15:0] settings [PHASES];
    settings = '{16'd2, 16'hffff, 16'd0, 16'd5, 16'd1, co2q_pkg::TIMEOUT_RESET};
    settings[3] = 16'($urandom_range(3, 8));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle block: byte, tick and the unused code all dropped
    offer(co2q_pkg::FUNC_TICK, 8'h00);
    offer(co2q_pkg::FUNC_BYTE, 8'hff);
    offer(FUNC_UNUSED, 8'h5a);
    // clean exchange, full-scale reading
    offer(co2q_pkg::FUNC_START, 8'h00);
    send_reply(8'hff, 8'hff, 1'b0, 1'b0, 1'b0);
    // reply abandoned by a second request, unused code mid-reply,
    // then a zero reading with a bad checksum
    offer(co2q_pkg::FUNC_START, 8'h00);
    offer(co2q_pkg::FUNC_BYTE, 8'hff);
    offer(FUNC_UNUSED, 8'h00);
    offer(co2q_pkg::FUNC_BYTE, 8'h86);
    offer(co2q_pkg::FUNC_START, 8'h00);
    send_reply(8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
    drain();

    // first tick times out; the next one finds the block idle
    write_timeout(16'd1);
    offer(co2q_pkg::FUNC_START, 8'h00);
    offer(co2q_pkg::FUNC_TICK, 8'h00);
    offer(co2q_pkg::FUNC_TICK, 8'h00);
    drain();

    // zero behaves as one
    write_timeout(16'd0);
    offer(co2q_pkg::FUNC_START, 8'h00);
    offer(co2q_pkg::FUNC_BYTE, 8'h12);
    offer(co2q_pkg::FUNC_TICK, 8'h00);
    drain();

    // full-width timer: a few ticks leave the reply pending
    write_timeout(16'hffff);
    offer(co2q_pkg::FUNC_START, 8'h00);
    repeat (8) offer(co2q_pkg::FUNC_TICK, 8'h00);

    // random phases, each under its own timeout setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_timeout(settings[p]);
      steady = (p == 2);
      // long receiver stall while requests keep coming: block fills and backs up
      if (p == 1) hold_req = 1'b1;
      target = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < target) random_sequence();
    end
    steady = 1'b0;
    drain();

    if (board.errors == 0)
      $display("co2_sensor_uart_query regression: pass");
    else
      $display("co2_sensor_uart_query regression: fail");
    $finish;
  end

endmodule
